// ===== src/tkm_pkg.sv =====
// ----------------------------------------------------------------------------
// tkm_pkg: shared types and constants of the k-way top-k merge
// Store geometry, transaction structs, candidate/best records and the
// sequencer state type used by all modules of the block.
// ----------------------------------------------------------------------------
package tkm_pkg;

   localparam int MAX_SOURCES = 8;
   localparam int MAX_K       = 64;

   localparam int SRC_W       = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int RANK_W      = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int ADDR_W      = SRC_W + RANK_W;
   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int NS_W        = $clog2(MAX_SOURCES + 1);
   localparam int CNT_W       = $clog2(MAX_K + 1);

   // Configuration register map (index = byte address / 4)
   localparam logic REG_NUM_SOURCES = 1'b0;
   localparam logic REG_TOP_COUNT   = 1'b1;

   localparam logic [3:0] NUM_SOURCES_RESET = 4'd2;
   localparam logic [6:0] TOP_COUNT_RESET   = 7'd10;

   typedef struct packed {
      logic [2:0]          source;
      logic [5:0]          rank;
      logic signed [31:0]  distance;
      logic signed [63:0]  label;
      logic                last_of_query;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  out_distance;
      logic signed [63:0]  out_label;
      logic [5:0]          out_rank;
      logic                last_result;
   } rsp_type;

   // One list head read back from the store, offered to the compare unit
   typedef struct packed {
      logic                valid;
      logic [SRC_W-1:0]    src;
      logic signed [31:0]  distance;
      logic signed [63:0]  label;
   } cand_type;

   // Running winner of the current scan
   typedef struct packed {
      logic                found;
      logic [SRC_W-1:0]    src;
      logic signed [31:0]  distance;
      logic signed [63:0]  label;
   } best_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST_CMP,
      ST_EMIT
   } state_type;

endpackage

// ===== src/tkm_store.sv =====
// ----------------------------------------------------------------------------
// tkm_store: distance and label store
// One write port for loaded entries and one registered read port for the
// merge sequencer. Entries are addressed by {source, rank}.
// ----------------------------------------------------------------------------
module tkm_store import tkm_pkg::*; (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic signed [31:0]  wr_distance,
   input  logic signed [63:0]  wr_label,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic signed [31:0]  rd_distance,
   output logic signed [63:0]  rd_label
);

   logic [31:0] distance_mem_ff [0:STORE_DEPTH-1];
   logic [63:0] label_mem_ff    [0:STORE_DEPTH-1];
   logic [31:0] rd_distance_ff;
   logic [63:0] rd_label_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         distance_mem_ff[wr_addr] <= wr_distance;
         label_mem_ff[wr_addr]    <= wr_label;
      end
      rd_distance_ff <= distance_mem_ff[rd_addr];
      rd_label_ff    <= label_mem_ff[rd_addr];
   end

   assign rd_distance = $signed(rd_distance_ff);
   assign rd_label    = $signed(rd_label_ff);

endmodule

// ===== src/tkm_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// tkm_cmp_unit: shared signed compare unit
// Takes one candidate per cycle and keeps the smallest distance seen since
// the last clear. Candidates arrive in ascending source order, so a strict
// compare keeps the lowest source on a tie.
// ----------------------------------------------------------------------------
module tkm_cmp_unit import tkm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      clear,
   input  cand_type  cand,
   output best_type  best
);

   best_type best_ff;
   best_type best_in;
   logic     take;

   assign take = cand.valid &&
                 (!best_ff.found || ($signed(cand.distance) < $signed(best_ff.distance)));

   always_comb begin
      best_in = best_ff;
      if (clear) begin
         best_in.found = 1'b0;
      end else if (take) begin
         best_in.found    = 1'b1;
         best_in.src      = cand.src;
         best_in.distance = cand.distance;
         best_in.label    = cand.label;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff.found <= 1'b0;
      end else begin
         best_ff.found <= best_in.found;
      end
      best_ff.src      <= best_in.src;
      best_ff.distance <= best_in.distance;
      best_ff.label    <= best_in.label;
   end

   assign best = best_ff;

endmodule

// ===== src/tkm_merge_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkm_merge_ctrl: load and merge sequencer
// Writes incoming entries to the store; on the last entry of a query it
// scans the list heads once per result through the shared compare unit and
// emits the winner through a registered output stage.
// ----------------------------------------------------------------------------
module tkm_merge_ctrl import tkm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [3:0]  num_sources,
   input  logic [6:0]  top_count,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload
);

   state_type           state_ff, state_in;
   logic [SRC_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [NS_W-1:0]     ns_ff, ns_in;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic [CNT_W-1:0]    head_ff [0:MAX_SOURCES-1];
   logic [CNT_W-1:0]    head_in [0:MAX_SOURCES-1];
   logic [CNT_W-1:0]    emitted_ff, emitted_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [SRC_W-1:0]    rd_src_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_payload_ff, rsp_payload_in;

   logic [NS_W-1:0]     ns_sat;
   logic [CNT_W-1:0]    k_sat;
   logic                req_fire;
   logic                start;
   logic                start_go;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [CNT_W-1:0]    head_cur;
   logic                scan_done;
   logic                out_free;
   logic                emit_fire;
   logic                last_emit;
   logic                cmp_clear;
   logic signed [31:0]  rd_distance;
   logic signed [63:0]  rd_label;
   cand_type            cand;
   best_type            best;

   // Saturate the configuration to what the store can hold
   assign ns_sat = (int'(num_sources) > MAX_SOURCES) ? NS_W'(MAX_SOURCES) : NS_W'(num_sources);
   assign k_sat  = (int'(top_count) > MAX_K) ? CNT_W'(MAX_K) : CNT_W'(top_count);

   assign req_fire  = req_valid && req_ready;
   assign start     = req_fire && req_payload.last_of_query;
   assign start_go  = start && (ns_sat != '0) && (k_sat != '0);
   assign wr_addr   = {SRC_W'(req_payload.source), RANK_W'(req_payload.rank)};
   assign head_cur  = head_ff[scan_idx_ff];
   assign rd_addr   = {scan_idx_ff, RANK_W'(head_cur)};
   assign scan_done = (NS_W'(scan_idx_ff) == (ns_ff - NS_W'(1)));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_emit = ((emitted_ff + CNT_W'(1)) == k_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_go) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_LAST_CMP;
            end
         end
         ST_LAST_CMP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!best.found) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               state_in = last_emit ? ST_IDLE : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_ready   = 1'b0;
      wr_en       = 1'b0;
      rd_valid_in = 1'b0;
      cmp_clear   = 1'b0;
      emit_fire   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            wr_en     = req_valid && (int'(req_payload.source) < MAX_SOURCES) &&
                        (int'(req_payload.rank) < MAX_K);
         end
         ST_SCAN: begin
            rd_valid_in = (head_cur < k_ff);
            cmp_clear   = (scan_idx_ff == '0);
         end
         ST_LAST_CMP: begin
         end
         ST_EMIT: begin
            emit_fire = best.found && out_free;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      scan_idx_in    = (state_ff == ST_SCAN) ? scan_idx_ff + SRC_W'(1) : '0;
      ns_in          = start ? ns_sat : ns_ff;
      k_in           = start ? k_sat : k_ff;
      emitted_in     = emitted_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      for (int s = 0; s < MAX_SOURCES; s++) begin
         head_in[s] = head_ff[s];
      end
      if (start) begin
         emitted_in = '0;
         for (int s = 0; s < MAX_SOURCES; s++) begin
            head_in[s] = '0;
         end
      end else if (emit_fire) begin
         emitted_in              = emitted_ff + CNT_W'(1);
         head_in[best.src]       = head_ff[best.src] + CNT_W'(1);
         rsp_valid_in            = 1'b1;
         rsp_payload_in.out_distance = best.distance;
         rsp_payload_in.out_label    = best.label;
         rsp_payload_in.out_rank     = 6'(emitted_ff);
         rsp_payload_in.last_result  = last_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_idx_ff  <= '0;
         ns_ff        <= '0;
         k_ff         <= '0;
         emitted_ff   <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < MAX_SOURCES; s++) begin
            head_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         ns_ff        <= ns_in;
         k_ff         <= k_in;
         emitted_ff   <= emitted_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int s = 0; s < MAX_SOURCES; s++) begin
            head_ff[s] <= head_in[s];
         end
      end
      rd_src_ff      <= scan_idx_ff;
      rsp_payload_ff <= rsp_payload_in;
   end

   tkm_store u_store (
      .clock       (clock),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_distance (req_payload.distance),
      .wr_label    (req_payload.label),
      .rd_addr     (rd_addr),
      .rd_distance (rd_distance),
      .rd_label    (rd_label)
   );

   assign cand.valid    = rd_valid_ff;
   assign cand.src      = rd_src_ff;
   assign cand.distance = rd_distance;
   assign cand.label    = rd_label;

   tkm_cmp_unit u_cmp (
      .clock (clock),
      .reset (reset),
      .clear (cmp_clear),
      .cand  (cand),
      .best  (best)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A scan always finds a live list, since fewer than k results are out.
   a_emit_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> best.found)
      else $error("merge scan found no live list");

   a_emitted_below_k: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (emitted_ff < k_ff))
      else $error("emitted count reached top count while merging");

   a_winner_live: assert property (@(posedge clock) disable iff (reset)
      emit_fire |-> (head_ff[best.src] < k_ff))
      else $error("winning list already exhausted");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (NS_W'(scan_idx_ff) < ns_ff))
      else $error("scan index beyond source count");

   a_emit_shown: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> (rsp_valid && (rsp_payload.out_rank == 6'($past(emitted_ff)))))
      else $error("emitted transaction not presented with its rank");

endmodule

// ===== src/topk_kway_merge.sv =====
// ----------------------------------------------------------------------------
// topk_kway_merge: k-way merge of sorted top-k lists
// Top level with the configuration registers and the merge sequencer.
// ----------------------------------------------------------------------------
// Usage. Each query is loaded as entries on the req_ channel, one transaction
// per cycle, each placed in the store at {source, rank}. The transaction with
// last_of_query set is stored as well and then starts the merge; while the
// merge runs req_ready is low. The merge gives top_count (at most 64) result
// transactions on the rsp_ channel in ascending distance order, each with its
// label and its rank in the merged list, and last_result set on the final
// one. On equal distances the list with the lowest source index wins.
// Every result costs one scan over the list heads through the shared compare
// unit, one store read per source; the store read port sets this cost.
// The result leaves through an output register: when the receiver stalls,
// the merge waits with the next winner, and the loading of the next query
// may begin while the final result is still waiting.
// Reset (synchronous) clears the sequencer, heads and output valid, and sets
// num_sources to 2 and top_count to 10; the store keeps no reset value.
// Configuration registers: num_sources at 0x0, top_count at 0x4, to be written
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module topk_kway_merge import tkm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // Configuration port
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready,
   // Entry channel
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_payload,
   // Result channel
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_payload
);

   logic [3:0] num_sources_ff, num_sources_in;
   logic [6:0] top_count_ff, top_count_in;
   logic       cfg_write;
   logic       reg_sel;

   // Registers are word aligned; bit 2 of the address picks the register.
   assign reg_sel   = paddr[2];
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      num_sources_in = num_sources_ff;
      top_count_in   = top_count_ff;
      if (cfg_write) begin
         case (reg_sel)
            REG_NUM_SOURCES: num_sources_in = pwdata[3:0];
            REG_TOP_COUNT:   top_count_in   = pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_NUM_SOURCES: prdata = {28'd0, num_sources_ff};
         REG_TOP_COUNT:   prdata = {25'd0, top_count_ff};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_sources_ff <= NUM_SOURCES_RESET;
         top_count_ff   <= TOP_COUNT_RESET;
      end else begin
         num_sources_ff <= num_sources_in;
         top_count_ff   <= top_count_in;
      end
   end

   // The sequencer latches the saturated configuration at the start of each
   // merge, so a register write between queries takes effect on the next one.
   tkm_merge_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .num_sources (num_sources_ff),
      .top_count   (top_count_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/tkm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tkm_checker: result predictor and scoreboard for the k-way top-k merge
// Watches the register port and both channels. It keeps its own copy of the
// entry store and the register values, and works out the merged list when a
// query closes. Each result transaction is checked in order against the
// oldest pending one.
// ----------------------------------------------------------------------------
module tkm_checker import tkm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic         pready,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_type      req_payload,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_type      rsp_payload,
   output int           pending_count,
   output int           fail_count
);

   localparam int REPORT_LIMIT = 10;

   logic signed [31:0] dist_mem  [STORE_DEPTH];
   logic signed [63:0] label_mem [STORE_DEPTH];
   logic [3:0]         cfg_sources;
   logic [6:0]         cfg_count;
   rsp_type            merged_q [$];
   int                 error_total = 0;

   // Store the entry; a closing entry then produces the whole merged list.
   task automatic load_entry(input req_type e);
      int                 n_src;
      int                 n_len;
      int                 emitted;
      int                 best;
      int                 slot;
      int                 head [MAX_SOURCES];
      bit                 found;
      logic signed [31:0] best_dist;
      rsp_type            r;
      if (int'(e.source) < MAX_SOURCES && int'(e.rank) < MAX_K) begin
         dist_mem[int'(e.source) * MAX_K + int'(e.rank)]  = e.distance;
         label_mem[int'(e.source) * MAX_K + int'(e.rank)] = e.label;
      end
      if (!e.last_of_query) return;
      n_src = (cfg_sources > MAX_SOURCES) ? MAX_SOURCES : int'(cfg_sources);
      n_len = (cfg_count > MAX_K) ? MAX_K : int'(cfg_count);
      foreach (head[s]) head[s] = 0;
      emitted = 0;
      while (emitted < n_len) begin
         found     = 1'b0;
         best      = 0;
         best_dist = '0;
         // Strict less-than keeps the lowest source on equal distances.
         for (int s = 0; s < n_src; s++) begin
            if (head[s] < n_len &&
                (!found || dist_mem[s * MAX_K + head[s]] < best_dist)) begin
               found     = 1'b1;
               best      = s;
               best_dist = dist_mem[s * MAX_K + head[s]];
            end
         end
         if (!found) break;
         slot           = best * MAX_K + head[best];
         r.out_distance = dist_mem[slot];
         r.out_label    = label_mem[slot];
         r.out_rank     = 6'(emitted);
         r.last_result  = (emitted + 1 == n_len);
         merged_q       = {merged_q, r};
         head[best]++;
         emitted++;
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (merged_q.size() == 0) begin
         error_total++;
         if (error_total <= REPORT_LIMIT)
            $display("%0t: unexpected result: dist %0d label %0d rank %0d last %0b",
                     $realtime, got.out_distance, got.out_label, got.out_rank,
                     got.last_result);
         return;
      end
      want = merged_q.pop_front();
      if (got.out_distance !== want.out_distance || got.out_label !== want.out_label ||
          got.out_rank !== want.out_rank || got.last_result !== want.last_result) begin
         error_total++;
         if (error_total <= REPORT_LIMIT)
            $display("%0t: result mismatch: expected dist %0d label %0d rank %0d last %0b, got dist %0d label %0d rank %0d last %0b",
                     $realtime, want.out_distance, want.out_label, want.out_rank,
                     want.last_result, got.out_distance, got.out_label, got.out_rank,
                     got.last_result);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_sources = NUM_SOURCES_RESET;
         cfg_count   = TOP_COUNT_RESET;
         merged_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if ((paddr >> 2) == REG_NUM_SOURCES)
               cfg_sources = pwdata[3:0];
            else if ((paddr >> 2) == REG_TOP_COUNT)
               cfg_count = pwdata[6:0];
         end
         // Results first, so a result cannot match an entry of the same edge.
         if (rsp_valid && rsp_ready) check_result(rsp_payload);
         if (req_valid && req_ready) load_entry(req_payload);
      end
      pending_count <= merged_q.size();
      fail_count    <= error_total;
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the k-way top-k merge
// Loads queries of mostly sorted (distance, label) lists under a range of register
// settings, with random gaps on both channels, while the checker predicts
// and compares every merged result.
// ----------------------------------------------------------------------------
module tb_top;
   import tkm_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 5;
   localparam int IDLE_PCT      = 21;
   localparam int ENTRY_TARGET  = 310;
   // A merge with no result never leaves idle; this pause is a margin only.
   localparam int SETTLE_CYCLES = 2 * (MAX_SOURCES + 2) + 20;
   // Cycles without any accepted transaction before the run is abandoned.
   localparam int STALL_LIMIT   = 4000;

   localparam logic signed [31:0] DIST_MIN   = 32'sh8000_0000;
   localparam logic signed [31:0] DIST_MAX   = 32'sh7fff_ffff;
   localparam logic signed [63:0] LABEL_MIN  = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] LABEL_MAX  = 64'sh7fff_ffff_ffff_ffff;
   localparam logic signed [63:0] LABEL_NONE = -64'sd1;

   // How the distances of one query are drawn.
   typedef enum int {
      SPREAD_WIDE,
      SPREAD_TIES,
      SPREAD_EXTREME
   } spread_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         psel        = 1'b0;
   logic         penable     = 1'b0;
   logic         pwrite      = 1'b0;
   logic [2:0]   paddr       = '0;
   logic [31:0]  pwdata      = '0;
   logic [31:0]  prdata;
   logic         pready;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   req_type      req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   rsp_type      rsp_payload;

   // High during a stretch of the run in which neither side idles.
   logic         steady      = 1'b0;
   int           pending_count;
   int           fail_count;
   int           entries_sent = 0;
   int           stall_cycles = 0;
   // Our own record of what the registers hold, used to shape each query.
   logic [3:0]   cur_sources  = NUM_SOURCES_RESET;
   logic [6:0]   cur_count    = TOP_COUNT_RESET;

   topk_kway_merge u_top (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   tkm_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // The result side stalls on about a fifth of the cycles, except during the
   // steady stretch, so that back-pressure lands on every stage of a merge.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Watchdog: a run that stops moving is a failure. Register writes count as
   // progress, so the settling pauses never come near the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic req_type make_entry(input int src, input int rank,
                                          input logic signed [31:0] entry_dist,
                                          input logic signed [63:0] lab,
                                          input bit last);
      req_type e;
      e.source        = 3'(src);
      e.rank          = 6'(rank);
      e.distance      = entry_dist;
      e.label         = lab;
      e.last_of_query = last;
      return e;
   endfunction

   function automatic logic signed [63:0] pick_label();
      case ($urandom_range(0, 9))
         0:       return LABEL_NONE;
         1:       return LABEL_MIN;
         2:       return LABEL_MAX;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic int pick_distance(input spread_type spread);
      case (spread)
         SPREAD_WIDE: return $urandom;
         // A narrow range makes equal distances across lists common.
         SPREAD_TIES: return int'($urandom_range(0, 6)) - 3;
         default: begin
            case ($urandom_range(0, 4))
               0:       return DIST_MIN;
               1:       return DIST_MAX;
               2:       return 0;
               3:       return -1;
               default: return int'($urandom_range(0, 2000)) - 1000;
            endcase
         end
      endcase
   endfunction

   // An entry anywhere in the store, with random content and no closing flag.
   function automatic req_type random_entry();
      return make_entry($urandom_range(0, MAX_SOURCES - 1), $urandom_range(0, MAX_K - 1),
                        pick_distance(SPREAD_WIDE), pick_label(), 1'b0);
   endfunction

   // Register write: a setup phase, an access phase, then a quiet phase so
   // that a following write never raises psel in the step that lowers it.
   task automatic write_reg(input logic idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_NUM_SOURCES)
         cur_sources = value[3:0];
      else
         cur_count = value[6:0];
      @(posedge clock);
   endtask

   // Holds the entry channel until every predicted result has been taken.
   // With settle set it also waits a margin before the registers may be
   // touched; a merge that produces nothing never leaves idle.
   task automatic wait_results(input bit settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_merge(input logic [3:0] sources, input logic [6:0] count);
      wait_results(1'b1);
      write_reg(REG_NUM_SOURCES, {28'd0, sources});
      write_reg(REG_TOP_COUNT, {25'd0, count});
   endtask

   // Offers one entry and returns at the edge where it is accepted. Valid is
   // only lowered for an idle cycle, never lowered and raised in one step.
   task automatic send_entry(input req_type item);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      entries_sent++;
      steady <= (entries_sent >= 140 && entries_sent < 220);
   endtask

   // One query under the current registers. Every list that the merge may
   // read is loaded in full, so no entry is ever read before it is written.
   // Most lists are sorted; some are not, some transactions land in lists
   // outside the merge, and the order of loading is sometimes scrambled.
   task automatic send_query();
      int         n_src;
      int         n_len;
      int         j;
      int         key;
      int         col [MAX_K];
      spread_type spread;
      bit         unsorted;
      req_type    batch [$];
      req_type    item;
      req_type    swap;
      n_src = (cur_sources > MAX_SOURCES) ? MAX_SOURCES : int'(cur_sources);
      n_len = (cur_count > MAX_K) ? MAX_K : int'(cur_count);
      if (n_src == 0 || n_len == 0) begin
         repeat ($urandom_range(1, 3)) batch = {batch, random_entry()};
      end else begin
         spread   = spread_type'($urandom_range(0, 2));
         unsorted = ($urandom_range(0, 99) < 10);
         if (n_src < MAX_SOURCES) begin
            repeat ($urandom_range(0, 2)) begin
               item        = random_entry();
               item.source = 3'($urandom_range(n_src, MAX_SOURCES - 1));
               batch       = {batch, item};
            end
         end
         for (int s = 0; s < n_src; s++) begin
            for (int r = 0; r < n_len; r++) col[r] = pick_distance(spread);
            if (!unsorted) begin
               for (int a = 1; a < n_len; a++) begin
                  key = col[a];
                  j   = a - 1;
                  while (j >= 0 && col[j] > key) begin
                     col[j + 1] = col[j];
                     j--;
                  end
                  col[j + 1] = key;
               end
            end
            for (int r = 0; r < n_len; r++)
               batch = {batch, make_entry(s, r, col[r], pick_label(), 1'b0)};
         end
         if ($urandom_range(0, 99) < 30) begin
            for (int a = batch.size() - 1; a > 0; a--) begin
               j        = $urandom_range(0, a);
               swap     = batch[a];
               batch[a] = batch[j];
               batch[j] = swap;
            end
         end
      end
      // The final transaction closes the query and starts the merge.
      for (int a = 0; a < batch.size(); a++) begin
         item               = batch[a];
         item.last_of_query = (a == batch.size() - 1);
         send_entry(item);
      end
   endtask

   initial begin : stimulus
      int                 phase;
      int                 queries;
      int                 idx;
      logic [3:0]         sources;
      logic [6:0]         count;
      logic signed [31:0] entry_dist;
      logic signed [63:0] lab;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: with no lists to merge, a closing transaction gives nothing.
      // The entry sits in the corner of the store with extreme fields.
      program_merge(4'd0, 7'd4);
      send_entry(make_entry(MAX_SOURCES - 1, MAX_K - 1, DIST_MIN, LABEL_MAX, 1'b1));

      // Directed: a result count of zero gives nothing either.
      program_merge(4'd3, 7'd0);
      send_entry(make_entry(0, 0, DIST_MAX, LABEL_MIN, 1'b1));

      // Directed: a source count above the maximum is clamped to all eight
      // lists of two entries. The lowest distance appears in source 0 twice
      // and heads source 7, so the tie must go to source 0 both times; the
      // other lists carry the upper extreme and small values around zero.
      program_merge(4'd15, 7'd2);
      for (idx = 0; idx < 2 * MAX_SOURCES; idx++) begin
         case (idx)
            0, 1, 14:   entry_dist = DIST_MIN;
            12, 13, 15: entry_dist = DIST_MAX;
            default:    entry_dist = idx / 3 - 2;
         endcase
         case (idx)
            0:       lab = LABEL_MIN;
            1:       lab = LABEL_MAX;
            14:      lab = LABEL_NONE;
            default: lab = {$urandom, $urandom};
         endcase
         send_entry(make_entry(idx / 2, idx % 2, entry_dist, lab,
                               idx == 2 * MAX_SOURCES - 1));
      end

      // Random phases. The first few visit the register extremes: a count
      // above the maximum (clamped to full lists), all lists with one entry,
      // clamped source counts, zero sources with a large count, and a zero
      // count. Later phases stay mostly small so that many queries fit.
      phase = 0;
      while (entries_sent < ENTRY_TARGET) begin
         case (phase)
            0: begin
               sources = 4'd1;
               count   = 7'd127;
               queries = 1;
            end
            1: begin
               sources = 4'd8;
               count   = 7'd1;
               queries = 3;
            end
            2: begin
               sources = 4'($urandom_range(9, 15));
               count   = 7'($urandom_range(2, 3));
               queries = 2;
            end
            3: begin
               sources = 4'd0;
               count   = 7'($urandom_range(65, 126));
               queries = 2;
            end
            4: begin
               sources = 4'($urandom_range(1, 3));
               count   = 7'd0;
               queries = 2;
            end
            default: begin
               sources = ($urandom_range(0, 99) < 20) ? 4'($urandom_range(5, 8)) :
                                                       4'($urandom_range(1, 4));
               count   = ($urandom_range(0, 99) < 15) ? 7'($urandom_range(9, 16)) :
                                                       7'($urandom_range(1, 8));
               queries = $urandom_range(2, 5);
            end
         endcase
         program_merge(sources, count);
         for (int q = 0; q < queries && entries_sent < ENTRY_TARGET; q++) begin
            send_query();
            // Now and then, and always in the first ordinary phase, the sender
            // holds off until the block has handed over every result.
            if (phase == 5 || $urandom_range(0, 99) < 25) wait_results(1'b0);
         end
         phase++;
      end

      wait_results(1'b1);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/tkm_pkg.sv
src/tkm_store.sv
src/tkm_cmp_unit.sv
src/tkm_merge_ctrl.sv
src/topk_kway_merge.sv
tb/tkm_checker.sv
tb/tb_top.sv
